>>> hw/rtl/mbd_pkg.sv
package mbd_pkg;

	// Field widths fixed by the item format
	localparam int ACTION_W = 2;
	localparam int IDX_W    = 3;
	localparam int CNT_W    = 6;
	localparam int MAP_W    = 6;

	// Defaults
	localparam int NUM_BUTTONS_DEF = 6;
	localparam logic [CNT_W-1:0] BOUNCE_RESET = CNT_W'(46);

	// Action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_EDGE = 2'd0,
		ACT_TICK = 2'd1,
		ACT_READ = 2'd2,
		ACT_PEEK = 2'd3
	} action_t;

	// Per-button control for one accepted item
	typedef struct packed {
		logic load;   // pin edge on this button
		logic tick;   // timer tick, all buttons
		logic clear;  // read clears the change flag
		logic press;  // pin reads pressed (low)
	} btn_ctrl_t;

endpackage

>>> hw/rtl/mbd_req_if.sv
interface mbd_req_if;
	logic                             valid;
	logic                             ready;
	logic [mbd_pkg::ACTION_W-1:0]     action;
	logic [mbd_pkg::IDX_W-1:0]        button_index;
	logic                             pin_level;

	modport source (output valid, action, button_index, pin_level, input ready);
	modport sink   (input valid, action, button_index, pin_level, output ready);
endinterface

>>> hw/rtl/mbd_rsp_if.sv
interface mbd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         pressed;
	logic                         changed;
	logic [mbd_pkg::MAP_W-1:0]    pressed_map;

	modport source (output valid, pressed, changed, pressed_map, input ready);
	modport sink   (input valid, pressed, changed, pressed_map, output ready);
endinterface

>>> hw/rtl/mbd_button.sv
module mbd_button (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbd_pkg::btn_ctrl_t            ctrl,
	input  logic [mbd_pkg::CNT_W-1:0]     bounce_ticks,
	output logic                          press_nxt,
	output logic                          flag_nxt
);

	logic [mbd_pkg::CNT_W-1:0] cnt_q, cnt_dec, cnt_d;
	logic pending_q, committed_q, flag_q;
	logic commit;
	logic flag_d;

	// Decrement a running count and commit when it lands on one
	always_comb begin
		cnt_dec = (cnt_q != '0) ? cnt_q - mbd_pkg::CNT_W'(1) : cnt_q;
		commit  = ctrl.tick && (cnt_dec == mbd_pkg::CNT_W'(1)) && (committed_q != pending_q);
		if (ctrl.load) begin
			cnt_d = bounce_ticks;
		end else if (ctrl.tick) begin
			cnt_d = cnt_dec;
		end else begin
			cnt_d = cnt_q;
		end
		press_nxt = commit ? pending_q : committed_q;
		flag_nxt  = commit | flag_q;
		flag_d    = ctrl.clear ? 1'b0 : flag_nxt;
	end

	// Hold the button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pending_q   <= 1'b0;
			committed_q <= 1'b0;
			flag_q      <= 1'b0;
		end else begin
			cnt_q       <= cnt_d;
			committed_q <= press_nxt;
			flag_q      <= flag_d;
			if (ctrl.load) begin
				pending_q <= ctrl.press;
			end
		end
	end

endmodule

>>> hw/rtl/multi_button_debouncer.sv
// Debouncer for NUM_BUTTONS active-low buttons. Every item on req (pin edge, timer tick,
// read-and-clear, peek) updates all button state in the cycle it is accepted and its
// result is registered into the output register on rsp, so the block takes one item per
// clock; req.ready drops only while a result sits in the output register and rsp.ready is
// low. The user must write bounce_ticks through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. bounce_ticks resets to 46. An out-of-range
// button_index reports pressed and changed as zero; pressed_map shows buttons 0 to 5 only.
module multi_button_debouncer #(
	parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mbd_req_if.sink                       req,
	mbd_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [mbd_pkg::CNT_W-1:0]     cfg_wdata
);

	logic [mbd_pkg::CNT_W-1:0] bounce_ticks_q;
	logic                      accept;
	logic [NUM_BUTTONS-1:0]    sel;
	logic [NUM_BUTTONS-1:0]    press_nxt;
	logic [NUM_BUTTONS-1:0]    flag_nxt;
	logic [mbd_pkg::MAP_W-1:0] map_nxt;

	logic                      rsp_valid_q;
	logic                      pressed_q;
	logic                      changed_q;
	logic [mbd_pkg::MAP_W-1:0] map_q;

	// Accept whenever the output register is free or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Hold the bounce setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_ticks_q <= mbd_pkg::BOUNCE_RESET;
		end else if (cfg_we) begin
			bounce_ticks_q <= cfg_wdata;
		end
	end

	// One cell per button
	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		mbd_pkg::btn_ctrl_t ctrl;

		assign sel[b]     = (6'(req.button_index) == 6'(b));
		assign ctrl.load  = accept && (req.action == mbd_pkg::ACT_EDGE) && sel[b];
		assign ctrl.tick  = accept && (req.action == mbd_pkg::ACT_TICK);
		assign ctrl.clear = accept && (req.action == mbd_pkg::ACT_READ) && sel[b];
		assign ctrl.press = !req.pin_level;

		mbd_button u_button (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.bounce_ticks (bounce_ticks_q),
			.press_nxt    (press_nxt[b]),
			.flag_nxt     (flag_nxt[b])
		);
	end

	// Map the first buttons into the pressed bitmap
	for (genvar m = 0; m < mbd_pkg::MAP_W; m++) begin : g_map
		if (m < NUM_BUTTONS) begin : g_used
			assign map_nxt[m] = press_nxt[m];
		end else begin : g_zero
			assign map_nxt[m] = 1'b0;
		end
	end

	// Load the result register on accept, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pressed_q <= |(press_nxt & sel);
			changed_q <= |(flag_nxt & sel);
			map_q     <= map_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.pressed     = pressed_q;
	assign rsp.changed     = changed_q;
	assign rsp.pressed_map = map_q;

endmodule

>>> hw/rtl/mbd_chk.sv
module mbd_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic [mbd_pkg::ACTION_W-1:0]  req_action,
	input  logic [mbd_pkg::IDX_W-1:0]     req_button_index,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic                          rsp_pressed,
	input  logic                          rsp_changed,
	input  logic [mbd_pkg::MAP_W-1:0]     rsp_pressed_map
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressed)
			&& $stable(rsp_changed) && $stable(rsp_pressed_map))
		else $error("stalled result changed");

	// Every accepted item shows a result in the next cycle
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("accepted item gave no result");

	// No item taken while a result is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("item accepted over a stalled result");

	// A peek right after a read of the same button sees the flag cleared
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_action == mbd_pkg::ACT_READ) ##1
		(req_acc && req_action == mbd_pkg::ACT_PEEK
			&& req_button_index == $past(req_button_index))
		|=> !rsp_changed)
		else $error("change flag survived a read");

	// The addressed level agrees with the bitmap
	a_map_match: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_button_index < 3'd6)
		|=> rsp_pressed == rsp_pressed_map[$past(req_button_index)])
		else $error("pressed disagrees with pressed_map");

endmodule

bind multi_button_debouncer mbd_chk u_mbd_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_action       (req.action),
	.req_button_index (req.button_index),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_pressed      (rsp.pressed),
	.rsp_changed      (rsp.changed),
	.rsp_pressed_map  (rsp.pressed_map)
);
